[rtl/lofs_pkg.sv]
package lofs_pkg;

	// Word format of every field: signed fixed point.
	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned FRACTION_BITS = 20;

	// Clock edges from the edge that takes start to the edge that takes the result.
	localparam int unsigned LATENCY = 10;

	localparam int unsigned NUM_COMP = 6;
	localparam int unsigned NUM_PAIRS = 21;
	localparam int unsigned NUM_TERMS = 9;
	localparam int unsigned NUM_GROUPS = 3;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [2*WORD_BITS-1:0] prod_t;
	typedef logic signed [WORD_BITS+1:0] part_t;
	typedef logic signed [WORD_BITS+3:0] acc_t;
	typedef logic [2:0] comp_idx_t;
	typedef logic [4:0] pair_idx_t;
	typedef logic [1:0] axis_t;

	// One input word: strain and inverse metric, symmetric storage order.
	typedef struct packed {
		word_t strain_xx;
		word_t strain_xy;
		word_t strain_xz;
		word_t strain_yy;
		word_t strain_yz;
		word_t strain_zz;
		word_t metric_xx;
		word_t metric_xy;
		word_t metric_xz;
		word_t metric_yy;
		word_t metric_yz;
		word_t metric_zz;
	} lofs_in_t;

	// One result word.
	typedef struct packed {
		word_t out_xx;
		word_t out_xy;
		word_t out_xz;
		word_t out_yy;
		word_t out_yz;
		word_t out_zz;
	} lofs_out_t;

	// Saturation limits and the rounding offset, held at product width.
	localparam prod_t WIDE_MAX = (prod_t'(1) <<< (WORD_BITS - 1)) - prod_t'(1);
	localparam prod_t WIDE_MIN = -(prod_t'(1) <<< (WORD_BITS - 1));
	localparam prod_t HALF = prod_t'(1) <<< (FRACTION_BITS - 1);

	// Two thirds, rounded to nearest, clipped to the word range.
	localparam longint TT_RAW = ((longint'(1) <<< (FRACTION_BITS + 2)) + 3) / 6;
	localparam word_t TWO_THIRDS = (TT_RAW > longint'(WIDE_MAX)) ?
		word_t'(WIDE_MAX) : word_t'(TT_RAW);

	// Symmetric tensor storage: (row, col) to component slot.
	localparam comp_idx_t SYM [3][3] = '{
		'{3'd0, 3'd1, 3'd2},
		'{3'd1, 3'd3, 3'd4},
		'{3'd2, 3'd4, 3'd5}
	};

	// Row and column of each result component.
	localparam axis_t OUT_ROW [NUM_COMP] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
	localparam axis_t OUT_COL [NUM_COMP] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

	// The 21 distinct products of two metric components.
	localparam comp_idx_t PAIR_A [NUM_PAIRS] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5
	};
	localparam comp_idx_t PAIR_B [NUM_PAIRS] = '{
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
		3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5
	};
	localparam pair_idx_t PAIR_IDX [NUM_COMP][NUM_COMP] = '{
		'{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5},
		'{5'd1, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10},
		'{5'd2, 5'd7, 5'd11, 5'd12, 5'd13, 5'd14},
		'{5'd3, 5'd8, 5'd12, 5'd15, 5'd16, 5'd17},
		'{5'd4, 5'd9, 5'd13, 5'd16, 5'd18, 5'd19},
		'{5'd5, 5'd10, 5'd14, 5'd17, 5'd19, 5'd20}
	};

	// Clip a wide signed value to the word range.
	function automatic word_t sat_wide(input prod_t v);
		word_t r;
		if (v > WIDE_MAX) begin
			r = word_t'(WIDE_MAX);
		end else if (v < WIDE_MIN) begin
			r = word_t'(WIDE_MIN);
		end else begin
			r = word_t'(v);
		end
		return r;
	endfunction

	// Round half up, drop the fraction bits, saturate.
	function automatic word_t fx_round(input prod_t p);
		prod_t r;
		r = p + HALF;
		r = r >>> FRACTION_BITS;
		return sat_wide(r);
	endfunction

	// Coefficient 2m - t, exact, then saturated.
	function automatic word_t coef_sat(input word_t m, input word_t t);
		prod_t v;
		v = prod_t'(m) + prod_t'(m) - prod_t'(t);
		return sat_wide(v);
	endfunction

endpackage

[rtl/longitudinal_operator_from_strain_unit.sv]
// Throughput: one word every cycle; busy stays low, since nothing downstream can stall.
// Ten register stages: operand capture, metric products, two-thirds scaling, coefficients,
// strain products and a two-level adder tree, each multiply registered.
// Reset (arst_n low, asynchronous) clears all valid bits; words in flight are dropped.
module longitudinal_operator_from_strain_unit
	import lofs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  lofs_in_t  operands,
	output logic      done,
	output lofs_out_t result
);

	logic accept;
	word_t g_in [NUM_COMP];
	word_t s_in [NUM_COMP];

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;

	word_t g_s1 [NUM_COMP];
	word_t st_s1 [NUM_COMP];
	prod_t pp_s2 [NUM_PAIRS];
	word_t st_s2 [NUM_COMP];
	word_t pw_s3 [NUM_PAIRS];
	word_t st_s3 [NUM_COMP];
	prod_t tp_s4 [NUM_PAIRS];
	word_t pw_s4 [NUM_PAIRS];
	word_t st_s4 [NUM_COMP];
	word_t tw_s5 [NUM_PAIRS];
	word_t pw_s5 [NUM_PAIRS];
	word_t st_s5 [NUM_COMP];
	word_t coef_s6 [NUM_COMP][NUM_TERMS];
	word_t st_s6 [NUM_COMP];
	prod_t termp_s7 [NUM_COMP][NUM_TERMS];
	word_t term_s8 [NUM_COMP][NUM_TERMS];
	part_t part_s9 [NUM_COMP][NUM_GROUPS];
	word_t out_s10 [NUM_COMP];

	// The pipeline never stalls, so a word is taken whenever start is high.
	assign busy = 1'b0;
	assign accept = start & ~busy;

	// Unpack the input word into index-addressed components.
	always_comb begin
		s_in[0] = operands.strain_xx;
		s_in[1] = operands.strain_xy;
		s_in[2] = operands.strain_xz;
		s_in[3] = operands.strain_yy;
		s_in[4] = operands.strain_yz;
		s_in[5] = operands.strain_zz;
		g_in[0] = operands.metric_xx;
		g_in[1] = operands.metric_xy;
		g_in[2] = operands.metric_xz;
		g_in[3] = operands.metric_yy;
		g_in[4] = operands.metric_yz;
		g_in[5] = operands.metric_zz;
	end

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	// Stage 1: capture the operands.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < NUM_COMP; c++) begin
				g_s1[c] <= g_in[c];
				st_s1[c] <= s_in[c];
			end
		end
	end

	// Stages 2 and 3: every distinct product of two metric components, then rounding.
	always_ff @(posedge clk) begin
		for (int p = 0; p < NUM_PAIRS; p++) begin
			pp_s2[p] <= prod_t'(g_s1[PAIR_A[p]]) * prod_t'(g_s1[PAIR_B[p]]);
			pw_s3[p] <= fx_round(pp_s2[p]);
		end
		for (int c = 0; c < NUM_COMP; c++) begin
			st_s2[c] <= st_s1[c];
			st_s3[c] <= st_s2[c];
		end
	end

	// Stages 4 and 5: scale each metric product by two thirds.
	always_ff @(posedge clk) begin
		for (int p = 0; p < NUM_PAIRS; p++) begin
			tp_s4[p] <= prod_t'(TWO_THIRDS) * prod_t'(pw_s3[p]);
			pw_s4[p] <= pw_s3[p];
			tw_s5[p] <= fx_round(tp_s4[p]);
			pw_s5[p] <= pw_s4[p];
		end
		for (int c = 0; c < NUM_COMP; c++) begin
			st_s4[c] <= st_s3[c];
			st_s5[c] <= st_s4[c];
		end
	end

	// Stage 6: coefficient 2 g^ik g^jl - 2/3 g^ij g^kl for every component and (k, l).
	always_ff @(posedge clk) begin
		for (int n = 0; n < NUM_COMP; n++) begin
			for (int k = 0; k < 3; k++) begin
				for (int l = 0; l < 3; l++) begin
					coef_s6[n][k*3+l] <= coef_sat(
						pw_s5[PAIR_IDX[SYM[OUT_ROW[n]][k]][SYM[OUT_COL[n]][l]]],
						tw_s5[PAIR_IDX[SYM[OUT_ROW[n]][OUT_COL[n]]][SYM[k][l]]]);
				end
			end
		end
		for (int c = 0; c < NUM_COMP; c++) begin
			st_s6[c] <= st_s5[c];
		end
	end

	// Stages 7 and 8: multiply each coefficient by its strain component, then round.
	always_ff @(posedge clk) begin
		for (int n = 0; n < NUM_COMP; n++) begin
			for (int k = 0; k < 3; k++) begin
				for (int l = 0; l < 3; l++) begin
					termp_s7[n][k*3+l] <= prod_t'(coef_s6[n][k*3+l])
						* prod_t'(st_s6[SYM[k][l]]);
					term_s8[n][k*3+l] <= fx_round(termp_s7[n][k*3+l]);
				end
			end
		end
	end

	// Stages 9 and 10: exact sum of the nine terms in two levels, then saturate.
	always_ff @(posedge clk) begin
		for (int n = 0; n < NUM_COMP; n++) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				part_s9[n][g] <= part_t'(term_s8[n][g*3]) + part_t'(term_s8[n][g*3+1])
					+ part_t'(term_s8[n][g*3+2]);
			end
			out_s10[n] <= sat_wide(prod_t'(acc_t'(part_s9[n][0]) + acc_t'(part_s9[n][1])
				+ acc_t'(part_s9[n][2])));
		end
	end

	// Result word and its strobe.
	assign done = valid_s10;
	assign result.out_xx = out_s10[0];
	assign result.out_xy = out_s10[1];
	assign result.out_xz = out_s10[2];
	assign result.out_yy = out_s10[3];
	assign result.out_yz = out_s10[4];
	assign result.out_zz = out_s10[5];

endmodule

[rtl/lofs_checker.sv]
module lofs_checker
	import lofs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// The pipeline takes a word in every cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised although the pipeline cannot stall");

	// Every accepted word yields a result strobe after the fixed latency.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted word produced no result");

	// No result appears without a word accepted the latency earlier.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching accepted word");

	// An idle input leaves the result strobe low the latency later.
	assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##LATENCY !done)
		else $error("result strobe after an idle cycle");

endmodule

bind longitudinal_operator_from_strain_unit lofs_checker u_lofs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done)
);
